FILE: rtl/core/btsc_pkg.sv
// ----------------------------------------------------------------------------
// btsc_pkg
// shared types and constants of the bulk transfer session checker
// ----------------------------------------------------------------------------
package btsc_pkg;

  localparam int unsigned SectorBytes = 512;
  localparam int unsigned MaxChunk    = 1048576;
  localparam logic [63:0] SectorMask  = 64'(SectorBytes - 1);

  typedef enum logic [3:0] {
    FUNC_INFO        = 4'd1,
    FUNC_BEGIN_READ  = 4'd2,
    FUNC_BEGIN_WRITE = 4'd3,
    FUNC_READ        = 4'd4,
    FUNC_WRITE       = 4'd5,
    FUNC_ACK         = 4'd6,
    FUNC_FINISH      = 4'd7,
    FUNC_CANCEL      = 4'd8,
    FUNC_CONTEXT     = 4'd9,
    FUNC_FILL        = 4'd10,
    FUNC_REBOOT      = 4'd11
  } func_t;

  typedef enum logic [4:0] {
    ERR_NONE          = 5'd0,
    ERR_CHECKSUM      = 5'd1,
    ERR_PAYLOAD       = 5'd2,
    ERR_REBOOT_BUSY   = 5'd3,
    ERR_CONTEXT       = 5'd4,
    ERR_BUSY          = 5'd5,
    ERR_BAD_REQUEST   = 5'd6,
    ERR_MOUNTED       = 5'd7,
    ERR_RANGE         = 5'd8,
    ERR_BAD_CHUNK     = 5'd9,
    ERR_FILL_IO       = 5'd10,
    ERR_FILL_VERIFY   = 5'd11,
    ERR_IO            = 5'd12,
    ERR_SYNC          = 5'd13,
    ERR_VERIFY        = 5'd14,
    ERR_BAD_ACK       = 5'd15,
    ERR_INCOMPLETE    = 5'd16,
    ERR_UNKNOWN       = 5'd17,
    ERR_WRITE_PREPARE = 5'd18
  } err_t;

  typedef enum logic [1:0] {
    CFG_BOOT_WRITE_ALLOWED = 2'd0,
    CFG_USER_CAPACITY      = 2'd1,
    CFG_BOOT0_CAPACITY     = 2'd2,
    CFG_BOOT1_CAPACITY     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    func_t       func;
    logic        hdr_bad;
    err_t        early_err;
    logic        begin_bad;
    logic        mounted;
    logic        range_bad;
    logic        chunk_bad;
    logic        region_hi;
    logic [1:0]  region;
    logic [1:0]  flags;
    logic        psize_wr_ok;
    logic        psize_zero;
    logic        ctx_ok;
    logic        io_ok;
    logic        verify_ok;
    logic [63:0] offset;
    logic [63:0] length;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  func;
    logic        status;
    err_t        err;
    logic [63:0] completed;
    logic [63:0] total;
    logic [1:0]  region;
    logic [20:0] read_bytes;
    logic        reboot;
  } reply_t;

endpackage

FILE: rtl/core/bulk_transfer_session_checker.sv
// ----------------------------------------------------------------------------
// bulk_transfer_session_checker
// keeps one storage transfer session and checks each command header against it
// ----------------------------------------------------------------------------
//   channel   handshake        payload
//   header    push / full      func, req_*, payload_size, status flags
//   reply     empty / pop      reply_*, error_code, read_bytes, reboot_request
//   config    cfg_write        cfg_index, cfg_data
//
// one header beat per cycle while the command queue is not full; the back stage
// updates the session as it takes each header, and a reply appears in the cycle
// after the back stage takes its header
// a two-entry command queue and a two-entry reply queue let each side stall alone
// synchronous reset clears the session, the registers and both queues
module bulk_transfer_session_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  func,
  input  logic [63:0] req_offset,
  input  logic [63:0] req_length,
  input  logic [31:0] payload_size,
  input  logic [31:0] req_region,
  input  logic [31:0] req_flags,
  input  logic        header_ok,
  input  logic        payload_crc_ok,
  input  logic        context_valid,
  input  logic        storage_mounted,
  input  logic        io_ok,
  input  logic        verify_ok,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  reply_func,
  output logic        reply_status,
  output logic [4:0]  error_code,
  output logic [63:0] reply_completed,
  output logic [63:0] reply_total,
  output logic [1:0]  reply_region,
  output logic [20:0] read_bytes,
  output logic        reboot_request
);

  import btsc_pkg::*;

  cmd_t   front_cmd;
  cmd_t   back_cmd;
  logic   cmd_empty;
  logic   cmd_take;
  reply_t back_reply;
  reply_t out_reply;
  logic   reply_push;
  logic   reply_full;

  btsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .func            (func),
    .req_offset      (req_offset),
    .req_length      (req_length),
    .payload_size    (payload_size),
    .req_region      (req_region),
    .req_flags       (req_flags),
    .header_ok       (header_ok),
    .payload_crc_ok  (payload_crc_ok),
    .context_valid   (context_valid),
    .storage_mounted (storage_mounted),
    .io_ok           (io_ok),
    .verify_ok       (verify_ok),
    .cmd             (front_cmd)
  );

  btsc_fifo #(
    .DEPTH  (2),
    .item_t (cmd_t)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_cmd),
    .rd_en   (cmd_take),
    .rd_data (back_cmd),
    .full    (full),
    .empty   (cmd_empty)
  );

  btsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!cmd_empty),
    .cmd         (back_cmd),
    .cmd_take    (cmd_take),
    .reply_ready (!reply_full),
    .reply_push  (reply_push),
    .reply       (back_reply)
  );

  btsc_fifo #(
    .DEPTH  (2),
    .item_t (reply_t)
  ) u_reply_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (reply_push),
    .wr_data (back_reply),
    .rd_en   (pop),
    .rd_data (out_reply),
    .full    (reply_full),
    .empty   (empty)
  );

  assign reply_func      = out_reply.func;
  assign reply_status    = out_reply.status;
  assign error_code      = out_reply.err;
  assign reply_completed = out_reply.completed;
  assign reply_total     = out_reply.total;
  assign reply_region    = out_reply.region;
  assign read_bytes      = out_reply.read_bytes;
  assign reboot_request  = out_reply.reboot;

  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("reply queue not empty after reset");

  a_cmd_queued : assert property (@(posedge clk) disable iff (rst)
    push && !full |=> !cmd_empty)
    else $error("accepted header beat lost before the back stage");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (reply_status == (error_code != ERR_NONE)))
    else $error("reply status disagrees with error code");

  a_fail_clean : assert property (@(posedge clk) disable iff (rst)
    !empty && reply_status |-> (read_bytes == '0) && !reboot_request)
    else $error("failed reply carries read data or reboot request");

endmodule

FILE: rtl/core/btsc_fifo.sv
// ----------------------------------------------------------------------------
// btsc_fifo
// small register queue, one beat in per cycle while not full and one out while not empty
// ----------------------------------------------------------------------------
module btsc_fifo #(
  parameter int DEPTH = 2,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_data,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  full,
  output logic  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t mem [DEPTH];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = count == CntW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = wr_en && !full;
  assign do_pop  = rd_en && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/btsc_front.sv
// ----------------------------------------------------------------------------
// btsc_front
// configuration registers and stateless classification of command headers
// ----------------------------------------------------------------------------
module btsc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [62:0]      cfg_data,
  input  logic [3:0]       func,
  input  logic [63:0]      req_offset,
  input  logic [63:0]      req_length,
  input  logic [31:0]      payload_size,
  input  logic [31:0]      req_region,
  input  logic [31:0]      req_flags,
  input  logic             header_ok,
  input  logic             payload_crc_ok,
  input  logic             context_valid,
  input  logic             storage_mounted,
  input  logic             io_ok,
  input  logic             verify_ok,
  output btsc_pkg::cmd_t   cmd
);

  import btsc_pkg::*;

  logic        boot_write_allowed;
  logic [62:0] user_capacity;
  logic [62:0] boot0_capacity;
  logic [62:0] boot1_capacity;

  func_t       f;
  logic [62:0] cap;
  logic [63:0] cap64;
  logic        data_func;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_write_allowed <= 1'b0;
      user_capacity      <= '0;
      boot0_capacity     <= '0;
      boot1_capacity     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BOOT_WRITE_ALLOWED: boot_write_allowed <= cfg_data[0];
        CFG_USER_CAPACITY:      user_capacity      <= cfg_data;
        CFG_BOOT0_CAPACITY:     boot0_capacity     <= cfg_data;
        CFG_BOOT1_CAPACITY:     boot1_capacity     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign f         = func_t'(func);
  assign data_func = (f == FUNC_WRITE) || (f == FUNC_CONTEXT) || (f == FUNC_FILL);

  always_comb begin
    case (req_region[1:0])
      2'd0:    cap = user_capacity;
      2'd1:    cap = boot0_capacity;
      default: cap = boot1_capacity;
    endcase
  end

  assign cap64 = {1'b0, cap};

  always_comb begin
    cmd.func    = f;
    cmd.hdr_bad = !header_ok || (payload_size > 32'(MaxChunk));
    if (!payload_crc_ok) begin
      cmd.early_err = ERR_CHECKSUM;
    end else if (!data_func && payload_size != '0) begin
      cmd.early_err = ERR_PAYLOAD;
    end else begin
      cmd.early_err = ERR_NONE;
    end
    cmd.begin_bad = (req_region > 32'd2) || (req_length == '0) ||
                    ((req_offset & SectorMask) != '0) ||
                    ((req_length & SectorMask) != '0) ||
                    (req_flags[31:2] != '0) ||
                    ((f == FUNC_BEGIN_WRITE) && (req_region == 32'd1) &&
                     !(boot_write_allowed && req_flags[0]));
    cmd.mounted   = storage_mounted;
    cmd.range_bad = ((f != FUNC_BEGIN_WRITE) && !io_ok) || (cap == '0) ||
                    (req_offset > cap64) || (req_length > cap64 - req_offset);
    cmd.chunk_bad = (req_length == '0) || (req_length > 64'(MaxChunk)) ||
                    ((req_length & SectorMask) != '0);
    cmd.region_hi   = req_region[31:2] != '0;
    cmd.region      = req_region[1:0];
    cmd.flags       = req_flags[1:0];
    cmd.psize_wr_ok = {32'b0, payload_size} == ((f == FUNC_FILL) ? 64'd4 : req_length);
    cmd.psize_zero  = payload_size == '0;
    cmd.ctx_ok      = context_valid;
    cmd.io_ok       = io_ok;
    cmd.verify_ok   = verify_ok;
    cmd.offset      = req_offset;
    cmd.length      = req_length;
  end

endmodule

FILE: rtl/core/btsc_back.sv
// ----------------------------------------------------------------------------
// btsc_back
// session state, progress checks and reply generation
// ----------------------------------------------------------------------------
module btsc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  btsc_pkg::cmd_t    cmd,
  output logic              cmd_take,
  input  logic              reply_ready,
  output logic              reply_push,
  output btsc_pkg::reply_t  reply
);

  import btsc_pkg::*;

  logic        session_active;
  logic        write_session;
  logic [1:0]  session_region;
  logic [1:0]  session_flags;
  logic [63:0] next_offset;
  logic [63:0] session_total;
  logic [63:0] bytes_completed;
  logic [63:0] bytes_remaining;
  logic [20:0] bytes_pending;

  logic        session_active_next;
  logic        write_session_next;
  logic [1:0]  session_region_next;
  logic [1:0]  session_flags_next;
  logic [63:0] next_offset_next;
  logic [63:0] session_total_next;
  logic [63:0] bytes_completed_next;
  logic [63:0] bytes_remaining_next;
  logic [20:0] bytes_pending_next;

  err_t        err;
  logic        emit;
  logic        load;
  logic        advance;
  logic        set_pending;
  logic        clear_pending;
  logic        rd_ok;
  logic        reboot;
  logic [63:0] adv;
  logic        chunk_fail;
  logic        ack_fail;
  logic        verify;

  assign cmd_take = cmd_valid && reply_ready;
  assign verify   = session_flags[1];

  assign chunk_fail = !session_active || (bytes_pending != '0) ||
                      ((cmd.func != FUNC_READ) != write_session) || cmd.chunk_bad ||
                      (cmd.offset != next_offset) || (cmd.length > bytes_remaining) ||
                      cmd.region_hi || (cmd.region != session_region) ||
                      (write_session ? !cmd.psize_wr_ok : !cmd.psize_zero);

  assign ack_fail = !session_active || write_session || (bytes_pending == '0) ||
                    (cmd.offset != next_offset + {43'b0, bytes_pending});

  always_comb begin
    err           = ERR_NONE;
    emit          = 1'b1;
    load          = 1'b0;
    advance       = 1'b0;
    set_pending   = 1'b0;
    clear_pending = 1'b0;
    rd_ok         = 1'b0;
    reboot        = 1'b0;
    if (cmd.hdr_bad) begin
      emit = 1'b0;
    end else if (cmd.early_err != ERR_NONE) begin
      err = cmd.early_err;
    end else begin
      case (cmd.func)
        FUNC_REBOOT: begin
          if (session_active) err = ERR_REBOOT_BUSY;
          else reboot = 1'b1;
        end
        FUNC_CONTEXT: begin
          if (session_active || !cmd.ctx_ok) err = ERR_CONTEXT;
        end
        FUNC_INFO: begin
          if (session_active) err = ERR_BUSY;
        end
        FUNC_BEGIN_READ, FUNC_BEGIN_WRITE: begin
          if (session_active || cmd.begin_bad) begin
            err = ERR_BAD_REQUEST;
          end else if (cmd.mounted) begin
            err = ERR_MOUNTED;
          end else if (cmd.range_bad) begin
            err = ERR_RANGE;
          end else begin
            load = 1'b1;
            if (cmd.func == FUNC_BEGIN_WRITE && !cmd.io_ok) err = ERR_WRITE_PREPARE;
          end
        end
        FUNC_READ, FUNC_WRITE, FUNC_FILL: begin
          if (chunk_fail) begin
            err = ERR_BAD_CHUNK;
          end else if (cmd.func == FUNC_FILL) begin
            if (!cmd.io_ok) err = ERR_FILL_IO;
            else if (verify && !cmd.verify_ok) err = ERR_FILL_VERIFY;
            else advance = 1'b1;
          end else if (!cmd.io_ok) begin
            err = ERR_IO;
          end else if (cmd.func == FUNC_WRITE) begin
            if (verify && !cmd.verify_ok) err = ERR_VERIFY;
            else advance = 1'b1;
          end else begin
            set_pending = 1'b1;
            rd_ok       = 1'b1;
          end
        end
        FUNC_ACK: begin
          if (ack_fail) begin
            err = ERR_BAD_ACK;
          end else begin
            advance       = 1'b1;
            clear_pending = 1'b1;
          end
        end
        FUNC_FINISH, FUNC_CANCEL: begin
          if (cmd.func == FUNC_CANCEL && !session_active) begin
            err = ERR_NONE;
          end else if (!session_active || (cmd.func == FUNC_FINISH &&
                       (bytes_pending != '0 || bytes_remaining != '0))) begin
            err = ERR_INCOMPLETE;
          end else if (write_session && !cmd.io_ok) begin
            err = ERR_SYNC;
          end else begin
            clear_pending = 1'b1;
          end
        end
        default: err = ERR_UNKNOWN;
      endcase
    end
  end

  assign adv = (cmd.func == FUNC_ACK) ? {43'b0, bytes_pending} : cmd.length;

  always_comb begin
    session_active_next  = session_active;
    write_session_next   = write_session;
    session_region_next  = session_region;
    session_flags_next   = session_flags;
    next_offset_next     = next_offset;
    session_total_next   = session_total;
    bytes_completed_next = bytes_completed;
    bytes_remaining_next = bytes_remaining;
    bytes_pending_next   = bytes_pending;
    if (load) begin
      session_active_next  = 1'b1;
      write_session_next   = cmd.func == FUNC_BEGIN_WRITE;
      session_region_next  = cmd.region;
      session_flags_next   = cmd.flags;
      next_offset_next     = cmd.offset;
      session_total_next   = cmd.length;
      bytes_completed_next = '0;
      bytes_remaining_next = cmd.length;
      bytes_pending_next   = '0;
    end
    if (advance) begin
      bytes_completed_next = bytes_completed + adv;
      next_offset_next     = next_offset + adv;
      bytes_remaining_next = bytes_remaining - adv;
    end
    if (set_pending) begin
      bytes_pending_next = cmd.length[20:0];
    end
    if (clear_pending) begin
      bytes_pending_next = '0;
    end
    // close the session on any failure, on a bad header and on a clean finish or cancel
    if (!emit || err != ERR_NONE ||
        ((cmd.func == FUNC_FINISH || cmd.func == FUNC_CANCEL) && clear_pending)) begin
      session_active_next = 1'b0;
      write_session_next  = 1'b0;
      bytes_pending_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active  <= 1'b0;
      write_session   <= 1'b0;
      session_region  <= '0;
      session_flags   <= '0;
      next_offset     <= '0;
      session_total   <= '0;
      bytes_completed <= '0;
      bytes_remaining <= '0;
      bytes_pending   <= '0;
    end else if (cmd_take) begin
      session_active  <= session_active_next;
      write_session   <= write_session_next;
      session_region  <= session_region_next;
      session_flags   <= session_flags_next;
      next_offset     <= next_offset_next;
      session_total   <= session_total_next;
      bytes_completed <= bytes_completed_next;
      bytes_remaining <= bytes_remaining_next;
      bytes_pending   <= bytes_pending_next;
    end
  end

  assign reply_push       = cmd_take && emit;
  assign reply.func       = cmd.func;
  assign reply.status     = err != ERR_NONE;
  assign reply.err        = err;
  assign reply.completed  = bytes_completed_next;
  assign reply.total      = session_total_next;
  assign reply.region     = session_region_next;
  assign reply.read_bytes = rd_ok ? cmd.length[20:0] : '0;
  assign reply.reboot     = reboot;

endmodule
